/* hdl/fir41_pkg.sv */
package fir41_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TAPS        = 41;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_COEF_BITS   = 16;

    // Result format
    localparam int OUT_BITS = 14;
    localparam int OUT_MAX  = 8191;
    localparam int OUT_MIN  = -8192;

    // Low-pass prototype, Q1.15, symmetric
    localparam int TABLE_LEN = 41;
    localparam int Q15_TABLE [TABLE_LEN] = '{
        -2, 4, 12, 29, 56, 98, 158, 240, 346, 476, 630, 805,
        998, 1200, 1403, 1599, 1777, 1928, 2042, 2113, 2138, 2113, 2042, 1928,
        1777, 1599, 1403, 1200, 998, 805, 630, 476, 346, 240, 158, 98,
        56, 29, 12, 4, -2
    };

    // Coefficient j rescaled to coef_bits; taps past the table are zero.
    // Narrower formats round half up.
    function automatic int coef_scaled(input int j, input int coef_bits);
        int c;
        int s;
        int half;
        c    = 0;
        s    = 0;
        half = 0;
        if (j < TABLE_LEN) begin
            c = Q15_TABLE[j];
            if (coef_bits >= 16) begin
                c = c * (1 << (coef_bits - 16));
            end else begin
                s    = 16 - coef_bits;
                half = (1 << s) >> 1;
                c    = (c + half) >>> s;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/fir_lowpass_41_tap_top.sv */
// 41-tap symmetric low-pass FIR, transposed form, one sample per clock unless the output stalls.
//
// Input channel : i_in_valid / o_in_ready, payload i_sample (unsigned ADC
//                 code) and i_frame_start. A transaction with frame_start set
//                 discards all earlier history: the frame is filtered as if
//                 preceded by zeros.
// Output channel: o_out_valid / i_out_ready, payload o_filtered (14-bit
//                 signed, rounded half up from Q1.15 and saturated).
//
// Throughput: one transaction per cycle while the receiver keeps up. Every
// accepted sample updates the whole chain of tap cells at once, each cell
// doing one constant multiply and one add into its own partial-sum register.
// Pipeline: the tap-0 cell registers the sum on the input edge; the
// round/saturate register loads from it once the output stage has room.
//
// Reset (i_rst_n low, synchronous) zeroes every partial sum, i.e. empty
// history, and drops both valid flags.
// Receiver stall: the output register holds; the tap-0 sum waits behind it,
// and o_in_ready falls only when both are full. The chain moves only on an
// accepted input, so stalls never disturb the filter state.
module fir_lowpass_41_tap_top #(
    parameter int TAPS        = fir41_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS = fir41_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = fir41_pkg::DEF_COEF_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_frame_start,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [fir41_pkg::OUT_BITS-1:0] o_filtered
);
    import fir41_pkg::*;

    // full product plus growth over all taps
    localparam int ACC_BITS = SAMPLE_BITS + 1 + COEF_BITS + $clog2(TAPS) + 1;

    logic signed [ACC_BITS-1:0] w_psum [TAPS+1];
    logic                       w_accept;
    logic                       w_os_ready;
    logic                       r_acc_valid;

    assign o_in_ready = !r_acc_valid || w_os_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_acc_valid <= i_in_valid;
        end
    end

    // Chain end: nothing older than the last tap
    assign w_psum[TAPS] = '0;

    // Cell k: p[k] <= c[k]*x + p[k+1]; cell 0 yields the finished sum
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        localparam logic signed [COEF_BITS-1:0] C_K =
            COEF_BITS'(coef_scaled(k, COEF_BITS));
        fir41_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS),
            .ACC_BITS    (ACC_BITS),
            .COEF        (C_K)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_accept),
            .i_clear  (i_frame_start),
            .i_sample (i_sample),
            .i_psum   (w_psum[k+1]),
            .o_psum   (w_psum[k])
        );
    end

    fir41_outstage #(
        .COEF_BITS (COEF_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_acc_valid),
        .i_acc      (w_psum[0]),
        .o_ready    (w_os_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_filtered (o_filtered)
    );
endmodule

/* hdl/fir41_cell.sv */
module fir41_cell #(
    parameter int SAMPLE_BITS = 12,
    parameter int COEF_BITS   = 16,
    parameter int ACC_BITS    = 36,
    parameter logic signed [COEF_BITS-1:0] COEF = '0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_clear,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    input  logic signed [ACC_BITS-1:0] i_psum,
    output logic signed [ACC_BITS-1:0] o_psum
);
    localparam int PROD_BITS = SAMPLE_BITS + 1 + COEF_BITS;

    logic signed [SAMPLE_BITS:0]   w_x;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [ACC_BITS-1:0]    w_in;
    logic signed [ACC_BITS-1:0]    n_psum;
    logic signed [ACC_BITS-1:0]    r_psum;

    assign w_x    = signed'({1'b0, i_sample});
    assign w_prod = PROD_BITS'(w_x) * PROD_BITS'(COEF);
    // frame start: older samples count as zero
    assign w_in   = i_clear ? '0 : i_psum;
    assign n_psum = ACC_BITS'(w_prod) + w_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
        end else if (i_en) begin
            r_psum <= n_psum;
        end
    end

    assign o_psum = r_psum;
endmodule

/* hdl/fir41_outstage.sv */
module fir41_outstage #(
    parameter int COEF_BITS = 16,
    parameter int ACC_BITS  = 36
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [ACC_BITS-1:0]  i_acc,
    output logic                        o_ready,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [fir41_pkg::OUT_BITS-1:0] o_filtered
);
    import fir41_pkg::*;

    localparam int FRAC_BITS = COEF_BITS - 1;
    localparam int SUM_BITS  = ACC_BITS + 1;

    logic signed [SUM_BITS-1:0] w_sum;
    logic signed [SUM_BITS-1:0] w_shift;
    logic signed [OUT_BITS-1:0] n_out;
    logic signed [OUT_BITS-1:0] r_out;
    logic                       r_valid;
    logic                       w_load;

    // round half up, then clamp
    assign w_sum   = SUM_BITS'(i_acc) + (SUM_BITS'(1) <<< (FRAC_BITS - 1));
    assign w_shift = w_sum >>> FRAC_BITS;

    always_comb begin
        if (w_shift > SUM_BITS'(OUT_MAX)) begin
            n_out = OUT_BITS'(OUT_MAX);
        end else if (w_shift < SUM_BITS'(OUT_MIN)) begin
            n_out = OUT_BITS'(OUT_MIN);
        end else begin
            n_out = w_shift[OUT_BITS-1:0];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_valid;
    assign o_filtered = r_out;
endmodule

/* dv/tb_fir_lowpass_41_tap_top.sv */
// Testbench for the 41-tap low-pass FIR.
//
// Flow: an initial block fills a backlog of ADC transactions (a short
// directed set, then randomly shaped frames), releases reset and waits for
// the filtered results to drain. A clocked driver presents the backlog on the
// input channel, and a clocked monitor checks every output transaction
// against an in-order queue of predicted samples. The predictor keeps its own
// delay line and coefficient copy, so it never looks inside the block.
//
// Pacing runs in three phases, selected by the transaction the driver is
// presenting: sender idle 21% / receiver idle 86%, then the reverse, then no
// idling at all. Both sides also drop into random calm stretches with no
// idling. The first transaction of each random phase is held back until every
// outstanding result has been checked, so the pipe fully empties at least
// once per phase.
module tb_fir_lowpass_41_tap_top;

    import fir41_pkg::*;

    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int CODE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int FILT_TAPS   = 41;
    localparam int RAND_ITEMS  = 1100;
    localparam int DRAIN_WAIT  = 8;

    // Low-pass prototype in Q1.15, tap 0 applies to the newest sample
    localparam int LP_TAPS_Q15 [FILT_TAPS] = '{
        -2, 4, 12, 29, 56, 98, 158, 240, 346, 476, 630, 805,
        998, 1200, 1403, 1599, 1777, 1928, 2042, 2113, 2138, 2113, 2042, 1928,
        1777, 1599, 1403, 1200, 998, 805, 630, 476, 346, 240, 158, 98,
        56, 29, 12, 4, -2
    };

    typedef struct {
        logic [SAMPLE_BITS-1:0] code;
        logic                   frame_start;
        int                     phase;
        bit                     hold;
    } t_adc_txn;

    // Clock, reset and DUT inputs, all known from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   in_valid      = 1'b0;
    logic [SAMPLE_BITS-1:0] in_code       = '0;
    logic                   in_frame_start = 1'b0;
    logic                   out_ready     = 1'b0;

    logic                          o_in_ready;
    logic                          o_out_valid;
    logic signed [OUT_BITS-1:0]    o_filtered;

    // Stimulus backlog and predicted outputs
    t_adc_txn                   adc_backlog [$];
    logic signed [OUT_BITS-1:0] filtered_due [$];
    logic [SAMPLE_BITS-1:0]     past_samples [FILT_TAPS-1];

    int total_items     = 0;
    int frame_count     = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int cur_phase       = 0;
    int out_min         = OUT_MAX;
    int out_max         = OUT_MIN;

    fir_lowpass_41_tap_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (in_code),
        .i_frame_start(in_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_filtered   (o_filtered)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Filter one accepted sample: clear history on a frame start, sum the
    // products, round half up out of Q1.15 (floor of sum + half), clamp to
    // the 14-bit range, then shift the sample into the delay line.
    function automatic logic signed [OUT_BITS-1:0] lowpass_next(
        input logic [SAMPLE_BITS-1:0] code,
        input logic                   frame_start
    );
        longint acc;
        longint y;
        if (frame_start) begin
            for (int j = 0; j < FILT_TAPS - 1; j++) past_samples[j] = '0;
        end
        acc = longint'(LP_TAPS_Q15[0]) * longint'(code);
        for (int j = 1; j < FILT_TAPS; j++) begin
            acc += longint'(LP_TAPS_Q15[j]) * longint'(past_samples[j-1]);
        end
        y = (acc + 64'sd16384) >>> 15;
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        for (int j = FILT_TAPS - 2; j > 0; j--) past_samples[j] = past_samples[j-1];
        past_samples[0] = code;
        return y[OUT_BITS-1:0];
    endfunction

    task automatic queue_txn(input int code, input bit fs, input int phase, input bit hold);
        t_adc_txn t;
        t.code        = code[SAMPLE_BITS-1:0];
        t.frame_start = fs;
        t.phase       = phase;
        t.hold        = hold;
        if (fs) frame_count++;
        adc_backlog.push_back(t);
    endtask

    task automatic note_failure(input string what, input int want, input int got);
        if (fail_count < 10) begin
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        end
        fail_count++;
    endtask

    // Per-phase idle percentages: index is the phase of the current transaction
    function automatic int send_idle_pct(input int phase);
        case (phase)
            0:       return 21;
            1:       return 86;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct(input int phase);
        case (phase)
            0:       return 86;
            1:       return 21;
            default: return 0;
        endcase
    endfunction

    // Driver: presents backlog transactions; valid holds until accepted.
    int send_calm = 0;
    always @(posedge i_clk) begin : drv_proc
        t_adc_txn t;
        bit       go;
        go = 1'b0;
        if (i_rst_n && !(in_valid && !o_in_ready)) begin
            if (in_valid) samples_sent++;
            if (send_calm > 0) begin
                send_calm--;
            end else if ($urandom_range(0, 99) < 3) begin
                send_calm = $urandom_range(10, 60);
            end
            if (adc_backlog.size() > 0) begin
                if (adc_backlog[0].hold && results_checked != samples_sent) begin
                    go = 1'b0;     // let the pipe drain completely first
                end else if (send_calm == 0 &&
                             $urandom_range(0, 99) < send_idle_pct(adc_backlog[0].phase)) begin
                    go = 1'b0;
                end else begin
                    go = 1'b1;
                end
            end
            if (go) begin
                t              = adc_backlog.pop_front();
                cur_phase      = t.phase;
                in_valid       <= 1'b1;
                in_code        <= t.code;
                in_frame_start <= t.frame_start;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks the output transaction first, then predicts from an
    // input accepted on the same edge (an input cannot reach the output on
    // the edge it is accepted, so the order is fixed).
    int recv_calm = 0;
    always @(posedge i_clk) begin : mon_proc
        logic signed [OUT_BITS-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (filtered_due.size() == 0) begin
                    note_failure("unexpected result", 0, o_filtered);
                end else begin
                    want = filtered_due.pop_front();
                    if (o_filtered !== want) note_failure("filtered mismatch", want, o_filtered);
                    if (int'(o_filtered) < out_min) out_min = o_filtered;
                    if (int'(o_filtered) > out_max) out_max = o_filtered;
                    results_checked++;
                end
            end
            if (in_valid && o_in_ready) begin
                filtered_due.push_back(lowpass_next(in_code, in_frame_start));
            end
            if (recv_calm > 0) begin
                recv_calm--;
            end else if ($urandom_range(0, 99) < 3) begin
                recv_calm = $urandom_range(10, 60);
            end
            out_ready <= (recv_calm > 0) || ($urandom_range(0, 99) >= recv_idle_pct(cur_phase));
        end
    end

    // Stimulus and end of test
    initial begin : main_proc
        int  rand_cnt;
        int  frame_len;
        int  mode;
        int  level;
        int  period;
        int  code;
        int  phase;
        int  prev_phase;
        int  r;
        bit  fs;

        for (int j = 0; j < FILT_TAPS - 1; j++) past_samples[j] = '0;

        // Directed: frame start on back-to-back items, full-scale and zero
        queue_txn(CODE_MAX, 1, 0, 0);
        queue_txn(0,        1, 0, 0);
        queue_txn(CODE_MAX, 1, 0, 0);
        queue_txn(CODE_MAX, 1, 0, 0);
        // full-scale step building into the history
        queue_txn(CODE_MAX, 1, 0, 0);
        queue_txn(CODE_MAX, 0, 0, 0);
        queue_txn(CODE_MAX, 0, 0, 0);
        queue_txn(CODE_MAX, 0, 0, 0);
        // mid-scale and single-bit codes, alternating bit patterns
        queue_txn(2048,  1, 0, 0);
        queue_txn(1,     0, 0, 0);
        queue_txn(2047,  0, 0, 0);
        queue_txn('hAAA, 0, 0, 0);
        queue_txn('h555, 0, 0, 0);
        // Nyquist-rate square wave: hits the negative edge taps hardest
        for (int k = 0; k < 8; k++) queue_txn((k % 2) ? 0 : CODE_MAX, k == 0, 0, 0);

        // Random frames with shaped content
        rand_cnt   = 0;
        prev_phase = -1;
        while (rand_cnt < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10)      frame_len = 1;
            else if (r < 25) frame_len = $urandom_range(41, 120);
            else             frame_len = $urandom_range(2, 40);
            mode   = $urandom_range(0, 3);
            level  = $urandom_range(0, CODE_MAX);
            period = $urandom_range(1, 20);
            for (int k = 0; k < frame_len && rand_cnt < RAND_ITEMS; k++) begin
                case (mode)
                    0: code = $urandom_range(0, CODE_MAX);
                    1: code = $urandom_range(0, 1) ? CODE_MAX : 0;
                    2: begin
                        code = level + $urandom_range(0, 64) - 32;
                        if (code < 0) code = 0;
                        if (code > CODE_MAX) code = CODE_MAX;
                    end
                    default: code = ((k / period) % 2) ? level : CODE_MAX - level;
                endcase
                // occasional stray frame start mid-frame
                fs    = (k == 0) || ($urandom_range(0, 49) == 0);
                phase = rand_cnt * 3 / RAND_ITEMS;
                queue_txn(code, fs, phase, phase != prev_phase);
                prev_phase = phase;
                rand_cnt++;
            end
        end
        total_items = adc_backlog.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(samples_sent == total_items && results_checked == samples_sent)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d ADC samples in %0d frames over three pacing phases; %0d results checked.",
                 total_items, frame_count, results_checked);
        $display("Filtered output spanned %0d to %0d; %0d failures.", out_min, out_max, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: many times the slowest correct run
    initial begin : watchdog_proc
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
